/* src/clm_pkg.sv */
// clm_pkg: shared widths, register codes and types of the community local-move block
// used by the channel interfaces, the register file and the top level
package clm_pkg;

   localparam int NODES_DEF  = 32;
   localparam int IDX_W      = 6;
   localparam int GAIN_W     = 32;
   localparam int SUM_W      = 48;
   localparam int RAW_W      = 16;
   localparam int MOVE_W     = 16;
   localparam int PASS_W     = 8;
   localparam int NCNT_W     = 7;
   localparam int MING_W     = 31;
   localparam int CSR_AW     = 4;
   localparam int CSR_DW     = 32;

   localparam logic [NCNT_W-1:0] NODE_COUNT_RST = 7'd32;
   localparam logic [PASS_W-1:0] MAX_PASSES_RST = 8'd10;
   localparam logic [MING_W-1:0] MIN_GAIN_RST   = '0;

   typedef enum logic [1:0] {
      CSR_NODE_COUNT = 2'd0,
      CSR_MAX_PASSES = 2'd1,
      CSR_MIN_GAIN   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [NCNT_W-1:0] node_count;
      logic [PASS_W-1:0] max_passes;
      logic [MING_W-1:0] min_gain;
   } cfg_type;

endpackage

/* src/clm_channels.sv */
// clm_req_if and clm_rsp_if: valid/ready channels for matrix words and result words
// depends on clm_pkg for field widths
interface clm_req_if;
   import clm_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [IDX_W-1:0]         row;
   logic [IDX_W-1:0]         col;
   logic signed [GAIN_W-1:0] gain;
   logic                     last;
   modport source (output valid, row, col, gain, last, input ready);
   modport sink   (input valid, row, col, gain, last, output ready);
endinterface

interface clm_rsp_if;
   import clm_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [IDX_W-1:0]        node;
   logic [IDX_W-1:0]        label;
   logic signed [SUM_W-1:0] score;
   logic [MOVE_W-1:0]       moved_count;
   logic [PASS_W-1:0]       pass_count;
   logic                    final_res;
   modport source (output valid, node, label, score, moved_count, pass_count, final_res,
                   input ready);
   modport sink   (input valid, node, label, score, moved_count, pass_count, final_res,
                   output ready);
endinterface

/* src/clm_csr.sv */
// clm_csr: apb register file holding node_count, max_passes and min_gain
// depends on clm_pkg
module clm_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [clm_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [clm_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [clm_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                         csr_pready,
   output clm_pkg::cfg_type             cfg
);
   import clm_pkg::*;

   cfg_type     cfg_ff;
   logic [1:0]  index;
   logic        wr_en;

   assign index      = csr_paddr[3:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.node_count <= NODE_COUNT_RST;
         cfg_ff.max_passes <= MAX_PASSES_RST;
         cfg_ff.min_gain   <= MIN_GAIN_RST;
      end else if (wr_en) begin
         unique case (index)
            CSR_NODE_COUNT: cfg_ff.node_count <= csr_pwdata[NCNT_W-1:0];
            CSR_MAX_PASSES: cfg_ff.max_passes <= csr_pwdata[PASS_W-1:0];
            CSR_MIN_GAIN:   cfg_ff.min_gain   <= csr_pwdata[MING_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         CSR_NODE_COUNT: csr_prdata = CSR_DW'(cfg_ff.node_count);
         CSR_MAX_PASSES: csr_prdata = CSR_DW'(cfg_ff.max_passes);
         CSR_MIN_GAIN:   csr_prdata = CSR_DW'(cfg_ff.min_gain);
         default:        csr_prdata = '0;
      endcase
   end

endmodule

/* src/community_local_move.sv */
// community_local_move: local-moving community detection over a stored pair-gain matrix
// depends on clm_pkg, clm_channels (clm_req_if, clm_rsp_if) and clm_csr
//
//   channel   dir   handshake        word
//   req_if    in    valid/ready      row, col, gain, last (one matrix entry)
//   rsp_if    out   valid/ready      node, label, score, moved_count, pass_count, final_res
//   csr_*     in    apb, pready=1    node_count, max_passes, min_gain at 0x0, 0x4, 0x8
//
// matrix words load at one per cycle; a word with last set starts a run and the
// block takes no word until the last result has been taken
// a run: labels are set to identity over all NODES entries, then each node visit
// scans once for its own community and once per neighbor community, with one more
// decision when the node may split off under a fresh label, bounded by the single
// read port of the gain store; relabel and score scan once per node in use; each
// result passes ST_ORD, ST_OLOAD and ST_OWAIT, waiting there for any stall on rsp_if
// reset is synchronous and clears control, the move and pass counts and the config registers; the gain store is
// not cleared and an unwritten pair reads as whatever it holds
module community_local_move #(
   parameter int NODES = clm_pkg::NODES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   clm_req_if.sink                      req_if,
   clm_rsp_if.source                    rsp_if,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [clm_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [clm_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [clm_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                         csr_pready
);
   import clm_pkg::*;

   localparam int NW  = $clog2(NODES);
   localparam int GAW = $clog2(NODES * NODES);

   // label store word: raw label during moves, first-appearance label afterwards
   typedef struct packed {
      logic [IDX_W-1:0] norm;
      logic [RAW_W-1:0] raw;
   } lab_word_type;

   typedef enum logic [13:0] {
      ST_IDLE   = 14'b00000000000001,
      ST_INIT   = 14'b00000000000010,
      ST_OWN    = 14'b00000000000100,
      ST_OWNW   = 14'b00000000001000,
      ST_SCAN   = 14'b00000000010000,
      ST_DRAIN  = 14'b00000000100000,
      ST_EVAL   = 14'b00000001000000,
      ST_DECIDE = 14'b00000010000000,
      ST_NEXT   = 14'b00000100000000,
      ST_COMMIT = 14'b00001000000000,
      ST_NWRITE = 14'b00010000000000,
      ST_ORD    = 14'b00100000000000,
      ST_OLOAD  = 14'b01000000000000,
      ST_OWAIT  = 14'b10000000000000
   } state_type;

   cfg_type cfg;

   clm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // memories
   logic signed [GAIN_W-1:0] gain_mem [NODES*NODES];
   lab_word_type             lab_mem  [NODES];
   logic signed [GAIN_W-1:0] gain_rd_ff;
   lab_word_type             lab_rd_ff;

   state_type state_ff, state_in;

   logic [NW-1:0]           idx_ff;       // visited node / relabel node / result node
   logic [NW-1:0]           o_ff;         // scan issue index
   logic [NW-1:0]           po_ff;        // scan index of data now at the read port
   logic                    pv_ff;        // read data valid
   logic [NW-1:0]           n_m1_ff;      // nodes in use minus one
   logic                    norm_ff;      // relabel phase
   logic [RAW_W-1:0]        own_ff;
   logic [RAW_W-1:0]        top_ff;
   logic [RAW_W-1:0]        cur_ff;       // candidate being summed
   logic                    cur_v_ff;
   logic [RAW_W-1:0]        next_ff;      // smallest candidate above cur seen so far
   logic                    nv_ff;
   logic                    first_ff;     // first scan of a visit
   logic                    mate_ff;      // own community has another member
   logic                    fresh_ff;     // fresh label already tried
   logic [RAW_W-1:0]        cand_ff;
   logic [RAW_W-1:0]        best_ff;
   logic signed [SUM_W-1:0] bestg_ff;
   logic signed [SUM_W-1:0] gval_ff;
   logic signed [SUM_W-1:0] add_ff;
   logic signed [SUM_W-1:0] rem_ff;
   logic signed [SUM_W-1:0] score_ff;
   logic                    moved_ff;
   logic [MOVE_W-1:0]       move_ff;
   logic [PASS_W-1:0]       pass_ff;
   logic                    found_ff;
   logic [IDX_W-1:0]        normv_ff;
   logic [NCNT_W-1:0]       labs_ff;

   // result register
   logic                    rsp_valid_ff;
   logic [IDX_W-1:0]        rsp_node_ff;
   logic [IDX_W-1:0]        rsp_label_ff;
   logic                    rsp_final_ff;

   function automatic logic [GAW-1:0] pair_addr(input logic [NW-1:0] a, input logic [NW-1:0] b);
      logic [NW-1:0] lo;
      logic [NW-1:0] hi;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      return GAW'(GAW'(lo) * GAW'(NODES)) + GAW'(hi);
   endfunction

   // load side
   logic             req_fire;
   logic             store_en;
   logic [GAW-1:0]   store_addr;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_if.valid & req_if.ready;
   assign store_en     = req_fire && (req_if.row < req_if.col) &&
                         ({1'b0, req_if.col} < NCNT_W'(NODES));
   assign store_addr   = GAW'(GAW'(req_if.row[NW-1:0]) * GAW'(NODES)) +
                         GAW'(req_if.col[NW-1:0]);

   // memory ports
   logic [NW-1:0]    lab_raddr;
   logic             lab_we;
   logic [NW-1:0]    lab_waddr;
   lab_word_type     lab_wdata;
   logic [GAW-1:0]   gain_raddr;

   always_comb begin
      lab_raddr  = (state_ff == ST_SCAN) ? o_ff : idx_ff;
      gain_raddr = pair_addr(idx_ff, o_ff);
      lab_we     = 1'b0;
      lab_waddr  = idx_ff;
      lab_wdata  = '0;
      unique case (state_ff)
         ST_INIT: begin
            lab_we        = 1'b1;
            lab_wdata.raw = RAW_W'(idx_ff);
         end
         ST_COMMIT: begin
            lab_we        = (best_ff != own_ff);
            lab_wdata.raw = best_ff;
         end
         ST_NWRITE: begin
            lab_we         = 1'b1;
            lab_wdata.raw  = own_ff;
            lab_wdata.norm = found_ff ? normv_ff : labs_ff[IDX_W-1:0];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (store_en) begin
         gain_mem[store_addr] <= req_if.gain;
      end
      gain_rd_ff <= gain_mem[gain_raddr];
   end

   always_ff @(posedge clock) begin
      if (lab_we) begin
         lab_mem[lab_waddr] <= lab_wdata;
      end
      lab_rd_ff <= lab_mem[lab_raddr];
   end

   // move decision: beat min_gain, and then either no move is chosen yet, beat the best
   // by more than min_gain, or come within min_gain with a lower label
   logic signed [SUM_W-1:0] mg;
   logic signed [SUM_W-1:0] diff;
   logic signed [SUM_W-1:0] absd;
   logic                    take;

   assign mg   = SUM_W'(cfg.min_gain);
   assign diff = gval_ff - bestg_ff;
   assign absd = diff[SUM_W-1] ? -diff : diff;
   assign take = (gval_ff > mg) &&
                 ((best_ff == own_ff) || (gval_ff > bestg_ff + mg) ||
                  ((absd <= mg) && (cand_ff < best_ff)));

   // data at the read port
   logic                    self;
   logic [RAW_W-1:0]        lr;
   logic signed [SUM_W-1:0] gx;
   logic                    last_node;
   logic                    stop_run;

   assign self      = (po_ff == idx_ff);
   assign lr        = lab_rd_ff.raw;
   assign gx        = {{(SUM_W-GAIN_W){gain_rd_ff[GAIN_W-1]}}, gain_rd_ff};
   assign last_node = (idx_ff == n_m1_ff);
   assign stop_run  = !(moved_ff || (best_ff != own_ff)) ||
                      (({1'b0, pass_ff} + 9'd1) == {1'b0, cfg.max_passes});

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_fire && req_if.last) state_in = ST_INIT;
         ST_INIT:   if (idx_ff == NW'(NODES - 1)) state_in = ST_OWN;
         ST_OWN:    state_in = ST_OWNW;
         ST_OWNW:   state_in = ST_SCAN;
         ST_SCAN:   if (o_ff == n_m1_ff) state_in = ST_DRAIN;
         ST_DRAIN:  state_in = norm_ff ? ST_NWRITE : ST_EVAL;
         ST_EVAL:   state_in = cur_v_ff ? ST_DECIDE : ST_NEXT;
         ST_DECIDE: state_in = ST_NEXT;
         ST_NEXT: begin
            if (nv_ff) state_in = ST_SCAN;
            else if (mate_ff && !fresh_ff) state_in = ST_DECIDE;
            else state_in = ST_COMMIT;
         end
         ST_COMMIT: state_in = ST_OWN;
         ST_NWRITE: state_in = last_node ? ST_ORD : ST_OWN;
         ST_ORD:    state_in = ST_OLOAD;
         ST_OLOAD:  state_in = ST_OWAIT;
         ST_OWAIT: begin
            if (rsp_if.ready) state_in = last_node ? ST_IDLE : ST_ORD;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         o_ff         <= '0;
         pv_ff        <= 1'b0;
         norm_ff      <= 1'b0;
         move_ff      <= '0;
         pass_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         n_m1_ff      <= '0;
      end else begin
         state_ff <= state_in;
         pv_ff    <= (state_ff == ST_SCAN);
         po_ff    <= o_ff;

         // consume scan data
         if (pv_ff) begin
            if (!norm_ff) begin
               if (first_ff) begin
                  if (lr > top_ff) top_ff <= lr;
                  if (!self && lr == own_ff) begin
                     rem_ff  <= rem_ff + gx;
                     mate_ff <= 1'b1;
                  end
               end
               if (cur_v_ff && !self && lr == cur_ff) add_ff <= add_ff + gx;
               if (!self && gain_rd_ff != '0 && lr != own_ff &&
                   (!cur_v_ff || lr > cur_ff) && (!nv_ff || lr < next_ff)) begin
                  next_ff <= lr;
                  nv_ff   <= 1'b1;
               end
            end else begin
               if (po_ff < idx_ff && lr == own_ff && !found_ff) begin
                  found_ff <= 1'b1;
                  normv_ff <= lab_rd_ff.norm;
               end
               if (po_ff > idx_ff && lr == own_ff) score_ff <= score_ff + gx;
            end
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire && req_if.last) begin
                  idx_ff  <= '0;
                  move_ff <= '0;
                  pass_ff <= '0;
                  norm_ff <= 1'b0;
                  if (cfg.node_count == '0) n_m1_ff <= '0;
                  else if (cfg.node_count > NCNT_W'(NODES)) n_m1_ff <= NW'(NODES - 1);
                  else n_m1_ff <= NW'(cfg.node_count - 7'd1);
               end
            end
            ST_INIT: begin
               if (idx_ff == NW'(NODES - 1)) begin
                  idx_ff   <= '0;
                  moved_ff <= 1'b0;
                  if (cfg.max_passes == '0) begin
                     norm_ff  <= 1'b1;
                     score_ff <= '0;
                     labs_ff  <= '0;
                  end
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            ST_OWNW: begin
               own_ff   <= lr;
               best_ff  <= lr;
               bestg_ff <= '0;
               rem_ff   <= '0;
               add_ff   <= '0;
               top_ff   <= '0;
               mate_ff  <= 1'b0;
               first_ff <= 1'b1;
               cur_v_ff <= 1'b0;
               nv_ff    <= 1'b0;
               fresh_ff <= 1'b0;
               found_ff <= 1'b0;
               o_ff     <= '0;
            end
            ST_SCAN: begin
               if (o_ff != n_m1_ff) o_ff <= o_ff + 1'b1;
            end
            ST_EVAL: begin
               first_ff <= 1'b0;
               if (cur_v_ff) begin
                  gval_ff <= add_ff - rem_ff;
                  cand_ff <= cur_ff;
               end
            end
            ST_DECIDE: begin
               if (take) begin
                  best_ff  <= cand_ff;
                  bestg_ff <= gval_ff;
               end
            end
            ST_NEXT: begin
               if (nv_ff) begin
                  cur_ff   <= next_ff;
                  cur_v_ff <= 1'b1;
                  nv_ff    <= 1'b0;
                  add_ff   <= '0;
                  o_ff     <= '0;
               end else if (mate_ff && !fresh_ff) begin
                  // fresh label: nobody holds it, so only the removal counts
                  cand_ff  <= top_ff + 1'b1;
                  gval_ff  <= -rem_ff;
                  fresh_ff <= 1'b1;
               end
            end
            ST_COMMIT: begin
               if (best_ff != own_ff) begin
                  moved_ff <= 1'b1;
                  if (move_ff != '1) move_ff <= move_ff + 1'b1;
               end
               if (last_node) begin
                  pass_ff  <= pass_ff + 1'b1;
                  idx_ff   <= '0;
                  moved_ff <= 1'b0;
                  if (stop_run) begin
                     norm_ff  <= 1'b1;
                     score_ff <= '0;
                     labs_ff  <= '0;
                  end
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            ST_NWRITE: begin
               if (!found_ff) labs_ff <= labs_ff + 1'b1;
               idx_ff <= last_node ? '0 : idx_ff + 1'b1;
            end
            ST_OLOAD: begin
               rsp_valid_ff <= 1'b1;
               rsp_node_ff  <= IDX_W'(idx_ff);
               rsp_label_ff <= lab_rd_ff.norm;
               rsp_final_ff <= last_node;
            end
            ST_OWAIT: begin
               if (rsp_if.ready) begin
                  rsp_valid_ff <= 1'b0;
                  if (!last_node) idx_ff <= idx_ff + 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.node        = rsp_node_ff;
   assign rsp_if.label       = rsp_label_ff;
   assign rsp_if.score       = score_ff;
   assign rsp_if.moved_count = move_ff;
   assign rsp_if.pass_count  = pass_ff;
   assign rsp_if.final_res   = rsp_final_ff;

endmodule

/* test/community_local_move_tb.sv */
`timescale 1ns / 100ps
// community_local_move_tb: loads pair-gain matrices, runs community detection at
// several register settings and checks every result word against a local predictor
// depends on clm_pkg, clm_channels and the community_local_move top level
module community_local_move_tb;
   import clm_pkg::*;

   localparam int NODES = NODES_DEF;

   typedef struct packed {
      logic [IDX_W-1:0]         row;
      logic [IDX_W-1:0]         col;
      logic signed [GAIN_W-1:0] gain;
      logic                     last;
   } matrix_word_type;

   typedef struct packed {
      logic [IDX_W-1:0]        node;
      logic [IDX_W-1:0]        label;
      logic signed [SUM_W-1:0] score;
      logic [MOVE_W-1:0]       moved_count;
      logic [PASS_W-1:0]       pass_count;
      logic                    final_res;
   } community_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   clm_req_if req_if ();
   clm_rsp_if rsp_if ();

   logic              csr_psel    = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0] csr_paddr   = '0;
   logic [CSR_DW-1:0] csr_pwdata  = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   community_local_move #(.NODES(NODES)) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // shared state between stimulus, driver, monitor and predictor
   matrix_word_type      pending_words[$];
   community_result_type expected_results[$];
   int                   error_count = 0;
   bit                   steady      = 0;  // no random idle gaps on either side while set
   bit                   hold_request = 0; // asks the receiver for one long hold-off
   int                   hold_cycles = 0;

   // predictor state: its own copy of the gain matrix, labels and registers
   logic signed [GAIN_W-1:0] gain_matrix[NODES*NODES];
   int                       community[NODES];
   int unsigned              cfg_node_count = NODE_COUNT_RST;
   int unsigned              cfg_max_passes = MAX_PASSES_RST;
   int unsigned              cfg_min_gain   = MIN_GAIN_RST;

   initial begin
      for (int i = 0; i < NODES*NODES; i++) gain_matrix[i] = '0;
      req_if.valid = 1'b0;
      req_if.row   = '0;
      req_if.col   = '0;
      req_if.gain  = '0;
      req_if.last  = 1'b0;
      rsp_if.ready = 1'b0;
   end

   function automatic void queue_word(matrix_word_type w);
      pending_words.insert(pending_words.size(), w);
   endfunction

   function automatic longint pair_gain(int a, int b);
      int lo, hi;
      lo = a < b ? a : b;
      hi = a < b ? b : a;
      return longint'(gain_matrix[lo*NODES + hi]);
   endfunction

   // gain of moving nd into target: links gained minus links left behind
   function automatic longint move_gain(int n, int nd, int target);
      longint removed, added;
      removed = 0;
      added   = 0;
      for (int o = 0; o < n; o++) begin
         if (o == nd) continue;
         if (community[o] == community[nd]) removed += pair_gain(nd, o);
         if (community[o] == target) added += pair_gain(nd, o);
      end
      return added - removed;
   endfunction

   // one node visit, returns 1 when the node changes community
   function automatic bit visit_node(int n, int nd);
      int     own, members, top, lbl, best, tmp;
      int     cand[$];
      bit     dup;
      longint mg, g, d, best_gain;
      own = community[nd];
      members = 0;
      top = 0;
      mg = longint'(cfg_min_gain);
      for (int i = 0; i < n; i++) begin
         lbl = community[i];
         if (lbl == own) members++;
         if (lbl > top) top = lbl;
         if (i == nd || pair_gain(nd, i) == 0 || lbl == own) continue;
         dup = 0;
         foreach (cand[j]) if (cand[j] == lbl) dup = 1;
         if (!dup) cand.insert(cand.size(), lbl);
      end
      // neighbor communities in ascending label order
      for (int i = 1; i < cand.size(); i++)
         for (int k = i; k > 0 && cand[k-1] > cand[k]; k--) begin
            tmp = cand[k];
            cand[k] = cand[k-1];
            cand[k-1] = tmp;
         end
      // a node sharing its community may split off under a fresh label
      if (members > 1) cand.insert(cand.size(), top + 1);
      best = own;
      best_gain = 0;
      foreach (cand[i]) begin
         g = move_gain(n, nd, cand[i]);
         d = g - best_gain;
         if (d < 0) d = -d;
         if (g > mg && (best == own || g > best_gain + mg || (d <= mg && cand[i] < best))) begin
            best = cand[i];
            best_gain = g;
         end
      end
      if (best != own) community[nd] = best;
      return best != own;
   endfunction

   // whole detection run, queues one result per node in use
   function automatic void detect_communities();
      int                   n, moves, passes, labs;
      int                   seen[NODES];
      bit                   moved;
      longint               score;
      community_result_type res;
      n = cfg_node_count < 1 ? 1 : (cfg_node_count > NODES ? NODES : cfg_node_count);
      for (int i = 0; i < NODES; i++) community[i] = i;
      moves = 0;
      passes = 0;
      for (int p = 0; p < cfg_max_passes; p++) begin
         moved = 0;
         for (int i = 0; i < n; i++)
            if (visit_node(n, i)) begin
               if (moves < 16'hFFFF) moves++;
               moved = 1;
            end
         passes = p + 1;
         if (!moved) break;
      end
      // renumber labels by first appearance
      labs = 0;
      for (int i = 0; i < n; i++) begin
         int j;
         for (j = 0; j < labs && seen[j] != community[i]; j++) ;
         if (j == labs) begin
            seen[labs] = community[i];
            labs++;
         end
         community[i] = j;
      end
      score = 0;
      for (int i = 0; i < n; i++)
         for (int j = i + 1; j < n; j++)
            if (community[i] == community[j]) score += pair_gain(i, j);
      for (int i = 0; i < n; i++) begin
         res.node        = i[IDX_W-1:0];
         res.label       = community[i][IDX_W-1:0];
         res.score       = score[SUM_W-1:0];
         res.moved_count = moves[MOVE_W-1:0];
         res.pass_count  = passes[PASS_W-1:0];
         res.final_res   = (i == n - 1);
         expected_results.insert(expected_results.size(), res);
      end
   endfunction

   function automatic void absorb_word(matrix_word_type w);
      // lower, diagonal and out-of-range pairs store nothing
      if (w.row < w.col && w.col < NODES) gain_matrix[w.row*NODES + w.col] = w.gain;
      if (w.last) detect_communities();
   endfunction

   // idle gaps: mostly none or short, a few long
   function automatic int gap_length();
      int pick;
      if (steady) return 0;
      pick = $urandom_range(99);
      if (pick < 55) return 0;
      if (pick < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   // driver: offers queued matrix words, feeds accepted words to the predictor
   int send_gap = 0;
   always @(posedge clock) begin
      if (req_if.valid && req_if.ready)
         absorb_word({req_if.row, req_if.col, req_if.gain, req_if.last});
      if (!req_if.valid || req_if.ready) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_if.valid <= 1'b0;
         end else if (pending_words.size() > 0 && !reset) begin
            matrix_word_type w;
            w = pending_words.pop_front();
            req_if.row   <= w.row;
            req_if.col   <= w.col;
            req_if.gain  <= w.gain;
            req_if.last  <= w.last;
            req_if.valid <= 1'b1;
            send_gap <= gap_length();
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // long receiver hold-off, counted on its own once a result word is waiting
   always @(posedge clock) begin
      if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
      else if (hold_request && rsp_if.valid) begin
         hold_cycles <= 600;
         hold_request <= 1'b0;
      end
   end

   // monitor: random ready, compares each result word with the oldest expectation
   int take_gap = 0;
   always @(posedge clock) begin
      if (rsp_if.valid && rsp_if.ready) begin
         community_result_type got, exp_res;
         got = {rsp_if.node, rsp_if.label, rsp_if.score, rsp_if.moved_count,
                rsp_if.pass_count, rsp_if.final_res};
         if (expected_results.size() == 0) begin
            error_count++;
            if (error_count <= 10) $display("unexpected result word: %p", got);
         end else begin
            exp_res = expected_results.pop_front();
            if (got !== exp_res) begin
               error_count++;
               if (error_count <= 10)
                  $display("result word differs: expected %p, actual %p", exp_res, got);
            end
         end
      end
      if (reset || hold_request || hold_cycles > 0) rsp_if.ready <= 1'b0;
      else if (take_gap > 0) begin
         take_gap <= take_gap - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
         take_gap <= gap_length();
      end
   end

   // register write: setup cycle, then access cycle
   task automatic csr_write(csr_index_type idx, logic [CSR_DW-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_AW'(int'(idx) * 4);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         CSR_NODE_COUNT: cfg_node_count = value[NCNT_W-1:0];
         CSR_MAX_PASSES: cfg_max_passes = value[PASS_W-1:0];
         default:        cfg_min_gain   = value[MING_W-1:0];
      endcase
   endtask

   // waits until every word is taken and every result is back
   task automatic wait_idle();
      do @(posedge clock);
      while (pending_words.size() > 0 || req_if.valid || expected_results.size() > 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic configure(int nc, int mp, int mg);
      wait_idle();
      csr_write(CSR_NODE_COUNT, nc);
      csr_write(CSR_MAX_PASSES, mp);
      csr_write(CSR_MIN_GAIN, mg);
   endtask

   function automatic logic signed [GAIN_W-1:0] random_gain();
      int pick;
      pick = $urandom_range(99);
      if (pick < 30) return '0;
      if (pick < 80) return $signed($urandom_range(32'h60000)) - 32'sh30000;
      if (pick < 90) return $urandom;
      return pick[0] ? 32'sh7FFFFFFF : 32'sh80000000;
   endfunction

   // word the block only stores nothing for: lower or diagonal, or past NODES
   function automatic matrix_word_type noise_word();
      matrix_word_type w;
      w.row = IDX_W'($urandom_range(63));
      w.col = $urandom_range(1) ? IDX_W'($urandom_range(63, NODES))
                                : IDX_W'($urandom_range(w.row));
      w.gain = $urandom;
      w.last = 1'b0;
      return w;
   endfunction

   // every pair of the first n nodes in shuffled order, some noise, last on the end
   task automatic queue_matrix(int n, int noise_pct, ref int counted);
      matrix_word_type set[$];
      matrix_word_type w, tmp;
      int k;
      for (int r = 0; r < n; r++)
         for (int c = r + 1; c < n; c++) begin
            w.row = IDX_W'(r);
            w.col = IDX_W'(c);
            w.gain = random_gain();
            w.last = 1'b0;
            set.insert(set.size(), w);
         end
      for (int i = set.size() - 1; i > 0; i--) begin
         k = $urandom_range(i);
         tmp = set[i];
         set[i] = set[k];
         set[k] = tmp;
      end
      counted += set.size();
      for (int i = 0; i < set.size(); i++)
         if ($urandom_range(99) < noise_pct) begin
            set.insert(i, noise_word());
            i++;
         end
      if (set.size() == 0 || $urandom_range(9) == 0) begin
         set.insert(set.size(), noise_word());
         counted++;
      end
      set[set.size() - 1].last = 1'b1;
      foreach (set[i]) queue_word(set[i]);
   endtask

   initial begin
      int counted, n;
      matrix_word_type w;
      counted = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: extreme gains on a pair, node count edges, zero passes, noise
      configure(2, 10, 0);
      w = '{row: 0, col: 1, gain: 32'sh7FFFFFFF, last: 1'b1};
      queue_word(w);
      w.gain = 32'sh80000000;
      queue_word(w);
      w.gain = 32'sh00000001;
      queue_word(w);
      configure(2, 10, 32'h7FFFFFFF);
      w.gain = 32'sh7FFFFFFF;
      queue_word(w);
      configure(0, 10, 0);                       // node count zero acts as one
      queue_word('{row: 63, col: 63, gain: 32'sh12345678, last: 1'b1});
      configure(4, 0, 0);                        // zero passes keep the identity
      queue_matrix(4, 0, counted);
      queue_word('{row: 0, col: 63, gain: -1, last: 1'b0});
      queue_word('{row: 45, col: 40, gain: 32'sh55555555, last: 1'b0});
      queue_word('{row: 2, col: 3, gain: 32'sh2AAAAAAA, last: 1'b1});
      configure(3, 255, 0);
      for (int r = 0; r < 3; r++)
         for (int c = r + 1; c < 3; c++)
            queue_word('{row: IDX_W'(r), col: IDX_W'(c), gain: 32'sh10000,
                         last: (r == 1)});

      // random: mostly small matrices, register settings changed before a random half of the sets
      counted = 0;
      while (counted < 50) begin
         n = $urandom_range(9) == 0 ? $urandom_range(16, 9) : $urandom_range(8, 2);
         if ($urandom_range(1)) begin
            case ($urandom_range(3))
               0: configure(n, $urandom_range(3), $urandom_range(32'h8000));
               1: configure(n, 255, 0);
               2: configure(n, $urandom_range(255), $urandom_range(32'h20000));
               default: configure(n, 10, $urandom_range(1) ? 32'h7FFFFFFF : $urandom);
            endcase
            steady = ($urandom_range(4) == 0);
         end else begin
            // back to back with the same node count, sender keeps offering
            if ($urandom_range(5) == 0) hold_request = 1'b1;
            n = cfg_node_count < 1 ? 1 : cfg_node_count;
         end
         queue_matrix(n, 15, counted);
      end

      // two larger matrices back to back under a long receiver hold-off
      steady = 0;
      configure(12, 2, 32'h100);
      hold_request = 1'b1;
      queue_matrix(12, 5, counted);
      queue_matrix(12, 5, counted);

      wait_idle();
      repeat (50) @(posedge clock);
      if (error_count == 0) $display("community_local_move: match");
      else $display("community_local_move: mismatch");
      $finish;
   end

   initial begin
      #1s;
      $display("community_local_move: mismatch");
      $finish;
   end

endmodule

/* community_local_move.f */
src/clm_pkg.sv
src/clm_channels.sv
src/clm_csr.sv
src/community_local_move.sv
test/community_local_move_tb.sv
